// ===== hw/rtl/lags_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_pkg
// Shared types, constants and the B3/S23 cell rule for the life automaton
// generation step.
// ----------------------------------------------------------------------------
package lags_pkg;

    // fixed field widths
    localparam int unsigned CFG_W      = 11;
    localparam int unsigned OUT_ROW_W  = 10;
    localparam int unsigned OUT_COL_W  = 10;
    localparam int unsigned WIN_W      = 9;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // register reset values
    localparam logic [CFG_W-1:0] BOARD_ROWS_RST = 11'd1024;
    localparam logic [CFG_W-1:0] BOARD_COLS_RST = 11'd1024;

    // window bits that survive into the edge evaluation (right column dead)
    localparam logic [WIN_W-1:0] WIN_EDGE_MASK = 9'h0DB;

    // input item codes
    typedef enum logic {
        FUNC_CELL  = 1'b0,
        FUNC_DRAIN = 1'b1
    } t_func;

    // register index, decoded from paddr[2]
    typedef enum logic {
        REG_BOARD_ROWS = 1'b0,
        REG_BOARD_COLS = 1'b1
    } t_reg_idx;

    // classified item handed from front to back
    typedef struct packed {
        logic                 cell_val;  // cell value after padding rules
        logic                 col_first; // item sits in column zero
        logic                 top_en;    // upper line store row lies on the board
        logic                 mid_en;    // middle line store row lies on the board
        logic                 emit;      // item completes a neighbourhood
        logic                 last;      // result is the final cell of the board
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
    } t_lags_ctrl;

    // birth on three neighbours, survival on two or three
    function automatic logic life_rule(input logic [WIN_W-1:0] win);
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < WIN_W; k++) begin
            if (k != 4) begin
                cnt = cnt + {3'b000, win[k]};
            end
        end
        return (cnt == 4'd3) || ((cnt == 4'd2) && win[4]);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lags_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_in_if / lags_out_if
// Valid/ready channels for the cell stream and the result stream.
// ----------------------------------------------------------------------------
interface lags_in_if;
    logic valid;
    logic ready;
    logic func;
    logic cell_alive;

    modport source (output valid, output func, output cell_alive, input ready);
    modport sink   (input valid, input func, input cell_alive, output ready);
endinterface

interface lags_out_if;
    logic       valid;
    logic       ready;
    logic       next_alive;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       frame_last;

    modport source (output valid, output next_alive, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input next_alive, input out_row, input out_col,
                    input frame_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lags_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_front
// Accepts cells, tracks the raster position and classifies each transaction
// (cell value, window edges, result position, end of board) for the back end.
// ----------------------------------------------------------------------------
module lags_front #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned MAX_ROWS = 1024
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    lags_in_if.sink                                 i_cell,
    input  wire  [lags_pkg::CFG_W-1:0]              i_board_rows,
    input  wire  [lags_pkg::CFG_W-1:0]              i_board_cols,
    input  wire                                     i_q_ready,
    output logic                                    o_q_push,
    output lags_pkg::t_lags_ctrl                    o_q_ctrl,
    output logic [$clog2(MAX_COLS)-1:0]             o_q_ci
);
    import lags_pkg::*;

    localparam int unsigned AW = $clog2(MAX_COLS);
    localparam int unsigned CW = $clog2(MAX_COLS + 1);
    localparam int unsigned RW = $clog2(MAX_ROWS + 3);

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;

    logic [RW-1:0] rows_eff, rows_p1, rows_p2, row_p1, erow;
    logic [CW-1:0] cols_eff, col_p1, ecol;
    logic          accept, col_first, emit, last, cell_v;

    // saturate the board size to 1..MAX
    always_comb begin
        priority if (i_board_rows == '0) begin
            rows_eff = RW'(1);
        end else if (32'(i_board_rows) > MAX_ROWS) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(i_board_rows);
        end
        priority if (i_board_cols == '0) begin
            cols_eff = CW'(1);
        end else if (32'(i_board_cols) > MAX_COLS) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = CW'(i_board_cols);
        end
    end

    assign rows_p1   = rows_eff + RW'(1);
    assign rows_p2   = rows_eff + RW'(2);
    assign row_p1    = r_row + RW'(1);
    assign col_p1    = r_col + CW'(1);
    assign col_first = (r_col == '0);

    // classification: column zero finishes the previous row's last cell
    always_comb begin
        if (col_first) begin
            emit = (r_row >= RW'(2)) && (r_row < rows_p2);
            erow = r_row - RW'(2);
            ecol = cols_eff - CW'(1);
            last = emit && (r_row == rows_p1);
        end else begin
            emit = (r_row != '0) && (r_row <= rows_eff);
            erow = r_row - RW'(1);
            ecol = r_col - CW'(1);
            last = emit && (r_row == rows_eff) && (r_col == cols_eff);
        end
    end

    // drains and cells below the board enter as dead
    assign cell_v = (t_func'(i_cell.func) == FUNC_CELL) && (r_row < rows_eff)
                    && i_cell.cell_alive;

    assign accept       = i_cell.valid && i_q_ready;
    assign i_cell.ready = i_q_ready;
    assign o_q_push     = accept;
    assign o_q_ci       = r_col[AW-1:0];

    always_comb begin
        o_q_ctrl.cell_val  = cell_v;
        o_q_ctrl.col_first = col_first;
        o_q_ctrl.top_en    = (r_row >= RW'(2));
        o_q_ctrl.mid_en    = (r_row != '0);
        o_q_ctrl.emit      = emit;
        o_q_ctrl.last      = last;
        o_q_ctrl.out_row   = OUT_ROW_W'(erow);
        o_q_ctrl.out_col   = OUT_COL_W'(ecol);
    end

    // raster position update
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            priority if (last) begin
                n_row = '0;
                n_col = '0;
            end else if (col_p1 >= cols_eff) begin
                n_col = '0;
                n_row = (row_p1 > rows_p1) ? '0 : row_p1;
            end else begin
                n_col = col_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lags_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_queue
// Four-entry register queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module lags_queue #(
    parameter int unsigned WIDTH = 36
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import lags_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned NW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count, n_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + NW'(1);
            2'b01:   n_count = r_count - NW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lags_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_back
// Line stores, 3x3 window and cell rule. One transaction per cycle unless
// o_result stalls: the line store is read as items leave the queue, written
// back as they move on, forwarding when consecutive items share a column.
// ----------------------------------------------------------------------------
module lags_back #(
    parameter int unsigned MAX_COLS = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_valid,
    input  wire  lags_pkg::t_lags_ctrl       i_q_ctrl,
    input  wire  [$clog2(MAX_COLS)-1:0]      i_q_ci,
    output logic                             o_q_pop,
    lags_out_if.source                       o_result
);
    import lags_pkg::*;

    localparam int unsigned AW = $clog2(MAX_COLS);

    // line store: bit 1 upper row, bit 0 middle row
    logic [1:0]       r_line_mem [MAX_COLS];
    logic [1:0]       r_rd;
    logic [AW:0]      r_fill;

    logic             r_s1_valid;
    t_lags_ctrl       r_s1_ctrl;
    logic [AW-1:0]    r_s1_ci;
    logic             r_s1_fill_ok;
    logic             r_s1_fwd;
    logic [1:0]       r_fwd_data;

    logic [WIN_W-1:0] r_win, n_win, eval_win;

    logic             r_out_valid;
    logic             r_out_alive;
    logic [9:0]       r_out_row, r_out_col;
    logic             r_out_last;

    logic             advance, wr_en;
    logic [1:0]       line_data;
    logic             top_v, mid_v;

    assign advance = !r_out_valid || o_result.ready;
    assign o_q_pop = advance && i_q_valid;
    assign wr_en   = advance && r_s1_valid;

    // stored rows: forwarded, or dead where never written since reset
    always_comb begin
        if (r_s1_fwd) begin
            line_data = r_fwd_data;
        end else if (r_s1_fill_ok) begin
            line_data = r_rd;
        end else begin
            line_data = 2'b00;
        end
    end

    assign top_v = r_s1_ctrl.top_en && line_data[1];
    assign mid_v = r_s1_ctrl.mid_en && line_data[0];

    // window shift; the left column always drops out
    always_comb begin
        if (r_s1_ctrl.col_first) begin
            eval_win = (r_win >> 1) & WIN_EDGE_MASK;
            n_win    = {r_s1_ctrl.cell_val, 2'b00, mid_v, 2'b00, top_v, 2'b00};
        end else begin
            n_win    = {r_s1_ctrl.cell_val, r_win[8], 1'b0,
                        mid_v, r_win[5], 1'b0,
                        top_v, r_win[2], 1'b0};
            eval_win = n_win;
        end
        if (r_s1_ctrl.last) begin
            n_win = '0;
        end
    end

    // line store read and write-back
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[r_s1_ci] <= {line_data[0], r_s1_ctrl.cell_val};
        end
        if (advance) begin
            r_rd <= r_line_mem[i_q_ci];
        end
    end

    // stage registers without reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ctrl    <= i_q_ctrl;
            r_s1_ci      <= i_q_ci;
            r_s1_fill_ok <= ({1'b0, i_q_ci} < r_fill);
            r_s1_fwd     <= r_s1_valid && (r_s1_ci == i_q_ci);
            r_fwd_data   <= {line_data[0], r_s1_ctrl.cell_val};
            r_out_alive  <= life_rule(eval_win);
            r_out_row    <= r_s1_ctrl.out_row;
            r_out_col    <= r_s1_ctrl.out_col;
            r_out_last   <= r_s1_ctrl.last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
            r_fill      <= '0;
        end else begin
            if (advance) begin
                r_s1_valid  <= i_q_valid;
                r_out_valid <= r_s1_valid && r_s1_ctrl.emit;
            end
            if (wr_en) begin
                r_win <= n_win;
                if ({1'b0, r_s1_ci} >= r_fill) begin
                    r_fill <= {1'b0, r_s1_ci} + (AW + 1)'(1);
                end
            end
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.next_alive = r_out_alive;
    assign o_result.out_row    = r_out_row;
    assign o_result.out_col    = r_out_col;
    assign o_result.frame_last = r_out_last;

endmodule
`default_nettype wire

// ===== hw/rtl/life_automaton_generation_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_generation_step
// One generation of the B3/S23 life automaton over a streamed raster board.
// ----------------------------------------------------------------------------
// Usage:
//  - i_cell takes one cell per transaction in raster order (func 0), then
//    board_cols+1 drain transactions (func 1) flush the last results.
//  - o_result gives the next state of the cell one row and one column
//    behind the input, with its position; frame_last marks the board's end.
//  - board_rows / board_cols are set over APB at byte addresses 0 and 4.
//  - Throughput: one transaction per cycle while o_result is not stalled, set
//    by the single line store port pair (one read, one write per cycle).
//  - The transaction that completes a neighbourhood passes the queue and
//    the line store read stage, then its result enters the output register.
//  - Reset clears counters, window and queue; line store contents are
//    tracked by a fill count, so no clearing pass is run.
//  - When o_result stalls, the back end holds and i_cell stays ready until
//    four transactions wait in the queue.
// ----------------------------------------------------------------------------
module life_automaton_generation_step #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned MAX_ROWS = 1024
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    lags_in_if.sink                             i_cell,
    lags_out_if.source                          o_result,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [lags_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [lags_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lags_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lags_pkg::*;

    localparam int unsigned AW = $clog2(MAX_COLS);
    localparam int unsigned QW = $bits(t_lags_ctrl) + AW;

    logic [CFG_W-1:0] r_board_rows, r_board_cols;
    t_reg_idx         reg_sel;
    logic             cfg_wr;

    logic             q_full, q_push, q_pop, q_valid;
    t_lags_ctrl       push_ctrl, pop_ctrl;
    logic [AW-1:0]    push_ci, pop_ci;
    logic [QW-1:0]    q_wdata, q_rdata;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_rows <= BOARD_ROWS_RST;
            r_board_cols <= BOARD_COLS_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_BOARD_ROWS: r_board_rows <= pwdata[CFG_W-1:0];
                REG_BOARD_COLS: r_board_cols <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BOARD_ROWS: prdata = APB_DATA_W'(r_board_rows);
            REG_BOARD_COLS: prdata = APB_DATA_W'(r_board_cols);
        endcase
    end

    // front end
    lags_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell       (i_cell),
        .i_board_rows (r_board_rows),
        .i_board_cols (r_board_cols),
        .i_q_ready    (!q_full),
        .o_q_push     (q_push),
        .o_q_ctrl     (push_ctrl),
        .o_q_ci       (push_ci)
    );

    // decoupling queue
    assign q_wdata  = {push_ctrl, push_ci};
    assign pop_ctrl = q_rdata[QW-1:AW];
    assign pop_ci   = q_rdata[AW-1:0];

    lags_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // back end
    lags_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ctrl  (pop_ctrl),
        .i_q_ci    (pop_ci),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lags_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lags_checker
// Port-level checks for the life automaton generation step, bound to the top.
// ----------------------------------------------------------------------------
module lags_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_next_alive,
    input wire [9:0]  i_out_row,
    input wire [9:0]  i_out_col,
    input wire        i_frame_last,
    input wire        i_psel,
    input wire        i_penable,
    input wire        i_pwrite,
    input wire [2:0]  i_paddr,
    input wire [31:0] i_pwdata,
    input wire [31:0] i_prdata,
    input wire        i_pready
);

    // reset leaves no result pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("result pending or input blocked after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_next_alive)
            && $stable(i_out_row) && $stable(i_out_col) && $stable(i_frame_last)))
        else $error("stalled result changed");

    // when the back end moves, the queue frees a slot for the input
    a_ready_after_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |=> i_in_ready)
        else $error("input blocked although the back end advanced");

    // register read after write returns the written size
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_pready) |=>
            (!(i_psel && !i_pwrite && (i_paddr[2] == $past(i_paddr[2])))
             || (i_prdata == 32'($past(i_pwdata[10:0])))))
        else $error("register read back differs from the last write");

endmodule

bind life_automaton_generation_step lags_checker u_lags_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_cell.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_next_alive (o_result.next_alive),
    .i_out_row    (o_result.out_row),
    .i_out_col    (o_result.out_col),
    .i_frame_last (o_result.frame_last),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata),
    .i_pready     (pready)
);
`default_nettype wire

// ===== verif/tb_life_automaton_generation_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_automaton_generation_step
// Self-checking bench for the streamed B3/S23 generation step. Boards of
// assorted sizes are streamed in raster order with random cell content and
// random gaps on both channels. A cycle-free predictor follows every accepted
// transaction and queues the expected next-state results, which are checked
// field by field against o_result in order.
// ----------------------------------------------------------------------------
module tb_life_automaton_generation_step;
    import lags_pkg::*;

    localparam int unsigned MAX_COLS     = 1024;
    localparam int unsigned MAX_ROWS     = 1024;
    localparam int unsigned SETTLE_WAIT  = 8;
    localparam int unsigned RANDOM_ITEMS = 900;

    // row end: left two columns move along, right column counts as dead
    localparam logic [WIN_W-1:0] KEEP_AT_ROW_END = 9'h0DB;
    // mid row: only the old right column survives, as the middle column
    localparam logic [WIN_W-1:0] KEEP_ON_SHIFT   = 9'h092;

    typedef struct packed {
        logic                 alive;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } t_cell_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lags_in_if  cell_if ();
    lags_out_if result_if ();

    life_automaton_generation_step #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (cell_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [CFG_W-1:0] board_rows_reg;
    logic [CFG_W-1:0] board_cols_reg;
    logic             line_two_up [MAX_COLS];
    logic             line_one_up [MAX_COLS];
    logic [WIN_W-1:0] nbhd_win;
    int unsigned      row_cnt;
    int unsigned      col_cnt;

    t_cell_result     next_gen_q [$];
    int unsigned      fault_count;
    int unsigned      items_sent;
    bit               burst_mode;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    // birth on three, survival on two or three; bit 4 is the centre cell
    function automatic logic b3s23(input logic [WIN_W-1:0] w);
        int unsigned n;
        n = 0;
        for (int k = 0; k < WIN_W; k++) begin
            if (k != 4) n += w[k];
        end
        return (n == 3) || (n == 2 && w[4]);
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned p;
        if (burst_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // one accepted transaction through the generation step
    task automatic predict_step(input t_func f, input logic alive);
        int unsigned  rows, cols, r, c, erow, ecol;
        logic         v, top, mid, emit, done;
        logic [WIN_W-1:0] rim_win;
        t_cell_result want;
        rows = clamp_size(board_rows_reg, MAX_ROWS);
        cols = clamp_size(board_cols_reg, MAX_COLS);
        r    = row_cnt;
        c    = col_cnt;
        v    = (f == FUNC_CELL && r < rows) ? alive : 1'b0;
        top  = (r >= 2) ? line_two_up[c % MAX_COLS] : 1'b0;
        mid  = (r >= 1) ? line_one_up[c % MAX_COLS] : 1'b0;
        emit = 1'b0;
        done = 1'b0;
        erow = 0;
        ecol = 0;
        want = '0;

        if (c == 0) begin
            // close off the last cell of the previous row
            rim_win = (nbhd_win >> 1) & KEEP_AT_ROW_END;
            if (r >= 2 && r - 2 < rows) begin
                emit       = 1'b1;
                erow       = r - 2;
                ecol       = cols - 1;
                want.alive = b3s23(rim_win);
            end
            nbhd_win = {v, 2'b00, mid, 2'b00, top, 2'b00};
        end else begin
            nbhd_win = ((nbhd_win >> 1) & KEEP_ON_SHIFT) | {v, 2'b00, mid, 2'b00, top, 2'b00};
            if (r >= 1 && r - 1 < rows) begin
                emit       = 1'b1;
                erow       = r - 1;
                ecol       = c - 1;
                want.alive = b3s23(nbhd_win);
            end
        end

        line_two_up[c % MAX_COLS] = line_one_up[c % MAX_COLS];
        line_one_up[c % MAX_COLS] = v;

        if (emit) begin
            done      = (erow == rows - 1) && (ecol == cols - 1);
            want.row  = erow[OUT_ROW_W-1:0];
            want.col  = ecol[OUT_COL_W-1:0];
            want.last = done;
            next_gen_q.push_back(want);
        end

        // raster position of the next transaction
        if (done) begin
            row_cnt  = 0;
            col_cnt  = 0;
            nbhd_win = '0;
        end else if (c + 1 >= cols) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt > rows + 1) row_cnt = 0;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // drive one transaction on i_cell, predicted once accepted
    task automatic send_item(input t_func f, input logic alive);
        int unsigned gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.func       <= f;
        cell_if.cell_alive <= alive;
        do @(posedge i_clk); while (!cell_if.ready);
        predict_step(f, alive);
        items_sent++;
    endtask

    // stop sending and let every expected result come out
    task automatic settle();
        int unsigned guard;
        guard = 0;
        @(negedge i_clk);
        cell_if.valid <= 1'b0;
        while (next_gen_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-CFG_W){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_BOARD_ROWS) board_rows_reg = val;
        else board_cols_reg = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_board(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        settle();
        write_reg(REG_BOARD_ROWS, rows);
        write_reg(REG_BOARD_COLS, cols);
    endtask

    // drain until the stream is back at row 0, column 0
    task automatic flush_board();
        while (row_cnt != 0 || col_cnt != 0) send_item(FUNC_DRAIN, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_cells(input int unsigned n, input int unsigned density);
        for (int unsigned i = 0; i < n; i++) begin
            send_item(FUNC_CELL, $urandom_range(0, 99) < density);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_cell_result want;
        t_cell_result got;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.alive = result_if.next_alive;
            got.row   = result_if.out_row;
            got.col   = result_if.out_col;
            got.last  = result_if.frame_last;
            if (next_gen_q.size() == 0) begin
                note_fault($sformatf("unexpected result row %0d col %0d alive %0b last %0b",
                                     got.row, got.col, got.alive, got.last));
            end else begin
                want = next_gen_q.pop_front();
                if (got.alive !== want.alive || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last) begin
                    note_fault($sformatf({"mismatch: expected row %0d col %0d alive %0b ",
                                          "last %0b, got row %0d col %0d alive %0b last %0b"},
                                         want.row, want.col, want.alive, want.last,
                                         got.row, got.col, got.alive, got.last));
                end
            end
        end
    end

    // result side back-pressure: phases of free flow, random and long stalls
    initial begin : drive_result_ready
        int unsigned mode;
        int unsigned mode_left;
        int unsigned stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= ($urandom_range(0, 3) != 0);
                2: result_if.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        result_if.ready <= 1'b0;
                    end else if ($urandom_range(0, 49) == 0) begin
                        stall_left = $urandom_range(10, 40);
                        result_if.ready <= 1'b0;
                    end else begin
                        result_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // single cell, full 3x3 board, drain inside the board, cells past the board
    task automatic test_directed_boards();
        burst_mode = 1'b0;
        set_board(11'd1, 11'd1);
        send_item(FUNC_CELL, 1'b1);
        send_item(FUNC_DRAIN, 1'b1);
        send_item(FUNC_DRAIN, 1'b0);

        set_board(11'd3, 11'd3);
        repeat (9) send_item(FUNC_CELL, 1'b1);
        repeat (4) send_item(FUNC_DRAIN, 1'b0);

        set_board(11'd2, 11'd2);
        send_item(FUNC_CELL, 1'b1);
        send_item(FUNC_DRAIN, 1'b1);
        send_item(FUNC_CELL, 1'b1);
        send_item(FUNC_CELL, 1'b1);
        repeat (3) send_item(FUNC_CELL, 1'b1);
    endtask

    // register extremes: zero and all ones saturate to 1 and the maximum
    task automatic test_size_extremes();
        burst_mode = 1'b1;
        set_board(11'h7FF, 11'h000);
        send_random_cells(64, 40);
        set_board(11'h000, 11'h000);
        flush_board();

        burst_mode = 1'b0;
        set_board(11'h000, 11'h7FF);
        send_random_cells(64, 50);
        set_board(11'd2, 11'd5);
        flush_board();
    endtask

    // size changes while a board is part way through
    task automatic test_mid_board_resize();
        burst_mode = 1'b0;
        // column counter already past the new width, row counter past the end
        set_board(11'd5, 11'd6);
        send_random_cells(16, 50);
        set_board(11'd1, 11'd3);
        flush_board();
        // board grows under way
        set_board(11'd4, 11'd5);
        send_random_cells(12, 50);
        set_board(11'd6, 11'd5);
        send_random_cells(8, 50);
        flush_board();
    endtask

    // random boards, mostly well formed, some cut short by a resize
    task automatic test_random_boards();
        int unsigned start, rows, cols, n, density, cut, pause_at;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                rows = $urandom_range(1, 8);
                cols = $urandom_range(1, 8);
            end else begin
                rows = $urandom_range(1, 40);
                cols = $urandom_range(1, 40);
            end
            set_board(CFG_W'(rows), CFG_W'(cols));
            burst_mode = ($urandom_range(0, 3) == 0);
            density    = $urandom_range(0, 100);
            n          = rows * cols;
            cut        = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
            pause_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;

            for (int unsigned i = 0; i < cut; i++) begin
                if (i == pause_at) settle();
                if ($urandom_range(0, 99) < 8) begin
                    send_item(FUNC_DRAIN, 1'($urandom_range(0, 1)));
                end else begin
                    send_item(FUNC_CELL, $urandom_range(0, 99) < density);
                end
            end

            if (cut < n) begin
                set_board(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)));
                flush_board();
            end else begin
                // tail: mostly drains, some plain cells that fall off the board
                for (int unsigned i = 0; i <= cols; i++) begin
                    if ($urandom_range(0, 99) < 85) begin
                        send_item(FUNC_DRAIN, 1'($urandom_range(0, 1)));
                    end else begin
                        send_item(FUNC_CELL, 1'($urandom_range(0, 1)));
                    end
                end
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cell_if.valid      = 1'b0;
        cell_if.func       = FUNC_CELL;
        cell_if.cell_alive = 1'b0;
        board_rows_reg     = BOARD_ROWS_RST;
        board_cols_reg     = BOARD_COLS_RST;
        nbhd_win           = '0;
        row_cnt            = 0;
        col_cnt            = 0;
        fault_count        = 0;
        items_sent         = 0;
        burst_mode         = 1'b0;
        for (int i = 0; i < MAX_COLS; i++) begin
            line_two_up[i] = 1'b0;
            line_one_up[i] = 1'b0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_boards();
        test_size_extremes();
        test_mid_board_resize();
        test_random_boards();

        settle();
        if (next_gen_q.size() != 0) begin
            note_fault($sformatf("%0d expected results never arrived", next_gen_q.size()));
        end
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lags_pkg.sv
hw/rtl/lags_if.sv
hw/rtl/lags_front.sv
hw/rtl/lags_queue.sv
hw/rtl/lags_back.sv
hw/rtl/life_automaton_generation_step.sv
hw/rtl/lags_checker.sv
verif/tb_life_automaton_generation_step.sv
